FILE: rtl/urdo_pkg.sv
`default_nettype none
package urdo_pkg;

  // Default sizes.
  localparam int DEF_NUM_SYMBOLS = 64;
  localparam int DEF_MAX_UNARY   = 64;

  // Field widths.
  localparam int SYM_W  = 6;
  localparam int CODE_W = 16;
  localparam int RULE_W = 16;
  localparam int CNT_W  = 7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [1:0] CFG_EPSILON      = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]  SYMBOL_COUNT_RST = 7'd64;
  localparam logic [CODE_W-1:0] EPSILON_RST      = 16'hFFFF;

  // Controller states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WAIT  = 3'd1;
  localparam logic [2:0] ST_P1_RD = 3'd2;
  localparam logic [2:0] ST_P1_EV = 3'd3;
  localparam logic [2:0] ST_P2_RD = 3'd4;
  localparam logic [2:0] ST_P2_EV = 3'd5;
  localparam logic [2:0] ST_PICK  = 3'd6;
  localparam logic [2:0] ST_SCAN  = 3'd7;

  // One stored unary rule.
  typedef struct packed {
    logic [RULE_W-1:0] rule;
    logic [SYM_W-1:0]  head;
    logic [SYM_W-1:0]  first;
  } store_entry_t;

endpackage
`default_nettype wire

FILE: rtl/unary_rule_dependency_order.sv
`default_nettype none
// Unary rule dependency order.
//
// Rules are presented on the in_ ports and taken at a clock edge where start
// is high and busy is low. Loading takes one rule per cycle while busy is
// low; each unary rule that fits in the rule store sets one bit in a row
// memory and a column memory (read, merge, write back, with forwarding
// between back-to-back rules) and is appended to the store. The rule marked
// final_rule raises busy and starts the run: a setup state, then the
// elimination pass over the symbols (N = NUM_SYMBOLS capped at 64), each
// read and then evaluated. Emission walks the symbols again; for each
// eliminated column it takes the pending heads, lowest first, and for each
// such pair scans the store once, one entry per cycle.
// Results appear on the out_ ports for exactly one cycle each, marked by
// out_valid; the last one carries out_last_result and is on the ports in the
// first cycle after busy falls. The receiver cannot stall the outputs, and
// configuration writes on the cfg_ channel are always accepted. Reset
// clears the control state and the row and column valid bits, so the
// matrix reads as empty without a clearing pass; the same happens at the
// end of every run.
module unary_rule_dependency_order #(
  parameter int NUM_SYMBOLS = urdo_pkg::DEF_NUM_SYMBOLS,
  parameter int MAX_UNARY   = urdo_pkg::DEF_MAX_UNARY
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [urdo_pkg::SYM_W-1:0]    in_head_symbol,
  input  wire logic [urdo_pkg::SYM_W-1:0]    in_first_symbol,
  input  wire logic [urdo_pkg::CODE_W-1:0]   in_second_symbol,
  input  wire logic [urdo_pkg::RULE_W-1:0]   in_rule_number,
  input  wire logic                          in_final_rule,
  output logic                               out_valid,
  output logic [urdo_pkg::RULE_W-1:0]        out_rule_number,
  output logic [urdo_pkg::SYM_W-1:0]         out_head_symbol,
  output logic                               out_has_rule,
  output logic                               out_cyclic_error,
  output logic                               out_overflow_error,
  output logic                               out_last_result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [urdo_pkg::CODE_W-1:0]   cfg_data
);

  import urdo_pkg::*;

  localparam int MAT_N = (NUM_SYMBOLS < 64) ? NUM_SYMBOLS : 64;
  localparam int SW    = $clog2(MAT_N);
  localparam int UCW   = $clog2(MAX_UNARY + 1);
  localparam int SAW   = (MAX_UNARY > 1) ? $clog2(MAX_UNARY) : 1;

  // Configuration registers.
  logic [CNT_W-1:0]  symbol_count_r;
  logic [CODE_W-1:0] epsilon_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= SYMBOL_COUNT_RST;
      epsilon_r      <= EPSILON_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYMBOL_COUNT: symbol_count_r <= cfg_data[CNT_W-1:0];
        CFG_EPSILON:      epsilon_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Symbols in use and the matching mask.
  logic [CNT_W-1:0] n_eff;
  logic [MAT_N-1:0] inuse;

  assign n_eff = (symbol_count_r < CNT_W'(MAT_N)) ? symbol_count_r : CNT_W'(MAT_N);

  always_comb begin
    for (int a = 0; a < MAT_N; a++) begin
      inuse[a] = (CNT_W'(a) < n_eff);
    end
  end

  // Control and run registers.
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] b_r;
  logic [SW-1:0]    a_r;
  logic [MAT_N-1:0] amask_r;
  logic [MAT_N-1:0] removed_r;
  logic             cyc_r;
  logic             ovf_r;
  logic [UCW-1:0]   unary_count_r;
  logic [UCW-1:0]   scan_i_r;
  logic             st_rdv_r;
  logic             pend_v_r;
  store_entry_t     pend_r;

  logic accept;
  logic unary_ok;
  logic store_full;
  logic b_last;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign store_full = (unary_count_r >= UCW'(MAX_UNARY));
  assign unary_ok   = (in_second_symbol == epsilon_r)
                      && ({1'b0, in_head_symbol} < n_eff)
                      && ({1'b0, in_first_symbol} < n_eff);
  assign b_last     = (b_r == CNT_W'(MAT_N - 1));

  // Load pipeline: rule waiting for its matrix write.
  logic          s1_v_r;
  logic [SW-1:0] s1_head_r;
  logic [SW-1:0] s1_first_r;
  logic          s1_rfwd_r;
  logic          s1_cfwd_r;

  // Matrix memories: rows indexed by head, columns indexed by first symbol.
  logic [MAT_N-1:0] rowmem [MAT_N];
  logic [MAT_N-1:0] colmem [MAT_N];
  logic [MAT_N-1:0] row_valid_r;
  logic [MAT_N-1:0] col_valid_r;
  logic [MAT_N-1:0] rd_row_r, rd_col_r;
  logic             rok_r, cok_r;
  logic [MAT_N-1:0] wr_row_r, wr_col_r;
  logic [SW-1:0]    raddr, caddr;
  logic [MAT_N-1:0] row_base, col_base, row_merged, col_merged;
  logic [MAT_N-1:0] row_eff, col_eff;

  assign raddr = (state_r == ST_IDLE) ? in_head_symbol[SW-1:0]  : b_r[SW-1:0];
  assign caddr = (state_r == ST_IDLE) ? in_first_symbol[SW-1:0] : b_r[SW-1:0];

  assign row_base   = s1_rfwd_r ? wr_row_r : (rok_r ? rd_row_r : '0);
  assign col_base   = s1_cfwd_r ? wr_col_r : (cok_r ? rd_col_r : '0);
  assign row_merged = row_base | (MAT_N'(1) << s1_first_r);
  assign col_merged = col_base | (MAT_N'(1) << s1_head_r);

  assign row_eff = (rok_r ? rd_row_r : '0) & inuse & ~removed_r;
  assign col_eff = cok_r ? rd_col_r : '0;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      rowmem[s1_head_r]  <= row_merged;
      colmem[s1_first_r] <= col_merged;
    end
    rd_row_r <= rowmem[raddr];
    rd_col_r <= colmem[caddr];
    wr_row_r <= row_merged;
    wr_col_r <= col_merged;
  end

  // Rule store, appended during loading and scanned during emission.
  store_entry_t store_mem [MAX_UNARY];
  store_entry_t st_rd_r;
  store_entry_t new_entry;

  assign new_entry = '{rule: in_rule_number, head: in_head_symbol, first: in_first_symbol};

  always_ff @(posedge clk) begin
    if (accept && unary_ok && !store_full) begin
      store_mem[unary_count_r[SAW-1:0]] <= new_entry;
    end
    st_rd_r <= store_mem[scan_i_r[SAW-1:0]];
  end

  // Lowest pending head in the current column.
  logic [SW-1:0] pick_a;
  logic          pick_found;

  always_comb begin
    pick_a     = '0;
    pick_found = 1'b0;
    for (int a = 0; a < MAT_N; a++) begin
      if (amask_r[a] && !pick_found) begin
        pick_a     = SW'(a);
        pick_found = 1'b1;
      end
    end
  end

  logic scan_issue;
  logic scan_match;

  assign scan_issue = (state_r == ST_SCAN) && (scan_i_r < unary_count_r);
  assign scan_match = st_rdv_r && (st_rd_r.head == SYM_W'(a_r))
                      && (st_rd_r.first == SYM_W'(b_r[SW-1:0]));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && in_final_rule) state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_P1_RD;
      ST_P1_RD: state_nxt = ST_P1_EV;
      ST_P1_EV: state_nxt = b_last ? ST_P2_RD : ST_P1_RD;
      ST_P2_RD: begin
        if (removed_r[b_r[SW-1:0]]) begin
          state_nxt = ST_P2_EV;
        end else if (b_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_P2_EV: state_nxt = ST_PICK;
      ST_PICK: begin
        if (pick_found) begin
          state_nxt = ST_SCAN;
        end else if (b_last) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_P2_RD;
        end
      end
      ST_SCAN:  if (!scan_issue && !st_rdv_r) state_nxt = ST_PICK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic run_end;
  assign run_end = ((state_r == ST_P2_RD) && !removed_r[b_r[SW-1:0]] && b_last)
                   || ((state_r == ST_PICK) && !pick_found && b_last);

  // Main control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      b_r           <= '0;
      a_r           <= '0;
      amask_r       <= '0;
      removed_r     <= '0;
      cyc_r         <= 1'b0;
      ovf_r         <= 1'b0;
      unary_count_r <= '0;
      scan_i_r      <= '0;
      st_rdv_r      <= 1'b0;
      pend_v_r      <= 1'b0;
      pend_r        <= '0;
      s1_v_r        <= 1'b0;
      s1_head_r     <= '0;
      s1_first_r    <= '0;
      s1_rfwd_r     <= 1'b0;
      s1_cfwd_r     <= 1'b0;
      rok_r         <= 1'b0;
      cok_r         <= 1'b0;
      row_valid_r   <= '0;
      col_valid_r   <= '0;
      out_valid          <= 1'b0;
      out_rule_number    <= '0;
      out_head_symbol    <= '0;
      out_has_rule       <= 1'b0;
      out_cyclic_error   <= 1'b0;
      out_overflow_error <= 1'b0;
      out_last_result    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      st_rdv_r  <= scan_issue;
      rok_r     <= row_valid_r[raddr];
      cok_r     <= col_valid_r[caddr];

      // Matrix write of the previous rule sets its row and column valid.
      if (s1_v_r) begin
        row_valid_r[s1_head_r]  <= 1'b1;
        col_valid_r[s1_first_r] <= 1'b1;
      end

      // Rule loading.
      s1_v_r <= 1'b0;
      if (accept && unary_ok) begin
        if (store_full) begin
          ovf_r <= 1'b1;
        end else begin
          unary_count_r <= unary_count_r + UCW'(1);
          s1_v_r        <= 1'b1;
        end
      end
      s1_head_r  <= in_head_symbol[SW-1:0];
      s1_first_r <= in_first_symbol[SW-1:0];
      s1_rfwd_r  <= s1_v_r && (s1_head_r == in_head_symbol[SW-1:0]);
      s1_cfwd_r  <= s1_v_r && (s1_first_r == in_first_symbol[SW-1:0]);

      if (state_r == ST_WAIT) begin
        b_r <= '0;
      end

      // Elimination pass: drop columns of symbols whose rows are empty.
      if (state_r == ST_P1_EV) begin
        if (b_r < n_eff) begin
          if (row_eff == '0) begin
            removed_r[b_r[SW-1:0]] <= 1'b1;
            if ((col_eff & ~inuse) != '0) cyc_r <= 1'b1;
          end else if (col_eff != '0) begin
            cyc_r <= 1'b1;
          end
        end else if (col_eff != '0) begin
          cyc_r <= 1'b1;
        end
        b_r <= b_last ? '0 : b_r + CNT_W'(1);
      end

      // Emission: walk eliminated columns.
      if (state_r == ST_P2_RD && !removed_r[b_r[SW-1:0]] && !b_last) begin
        b_r <= b_r + CNT_W'(1);
      end
      if (state_r == ST_P2_EV) begin
        amask_r <= col_eff & inuse;
      end
      if (state_r == ST_PICK) begin
        if (pick_found) begin
          a_r              <= pick_a;
          amask_r[pick_a]  <= 1'b0;
          scan_i_r         <= '0;
        end else if (!b_last) begin
          b_r <= b_r + CNT_W'(1);
        end
      end
      if (scan_issue) begin
        scan_i_r <= scan_i_r + UCW'(1);
      end

      // A match is held back one step so the last result can be marked.
      if (scan_match) begin
        if (pend_v_r) begin
          out_valid          <= 1'b1;
          out_rule_number    <= pend_r.rule;
          out_head_symbol    <= pend_r.head;
          out_has_rule       <= 1'b1;
          out_cyclic_error   <= cyc_r;
          out_overflow_error <= ovf_r;
          out_last_result    <= 1'b0;
        end
        pend_v_r <= 1'b1;
        pend_r   <= st_rd_r;
      end

      // End of run: final result, then clear the run state.
      if (run_end) begin
        out_valid          <= 1'b1;
        out_rule_number    <= pend_v_r ? pend_r.rule : '0;
        out_head_symbol    <= pend_v_r ? pend_r.head : '0;
        out_has_rule       <= pend_v_r;
        out_cyclic_error   <= cyc_r;
        out_overflow_error <= ovf_r;
        out_last_result    <= 1'b1;
        pend_v_r      <= 1'b0;
        removed_r     <= '0;
        cyc_r         <= 1'b0;
        ovf_r         <= 1'b0;
        unary_count_r <= '0;
        row_valid_r   <= '0;
        col_valid_r   <= '0;
        b_r           <= '0;
      end
    end
  end

  // The final result closes the run.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> !busy)
    else $error("last result while still busy");

  // An empty result is always the last one.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_rule) |-> out_last_result)
    else $error("empty result not marked last");

  // The store count never passes its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    unary_count_r <= UCW'(MAX_UNARY))
    else $error("unary store count beyond capacity");

  // Every matrix write lands before the pass reads the matrix.
  a_write_first: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (state_r == ST_IDLE || state_r == ST_WAIT))
    else $error("matrix write pending during the pass");

endmodule
`default_nettype wire
